// ===== rtl/core/lfd_pkg.sv =====
package lfd_pkg;

	// Fixed-point format of the current level.
	localparam int FRAC_BITS = 16;
	localparam int PCT_W     = 7;
	localparam int TMS_W     = 15;
	localparam int LEVEL_W   = PCT_W + FRAC_BITS;
	localparam int STEP_W    = LEVEL_W + 1;
	localparam int CNT_W     = $clog2(LEVEL_W);

	localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ON_MIN = 7'd49;
	localparam logic [PCT_W-1:0] ON_LEVEL_RESET = 7'd100;

	// Duty scaling: y = (level * 255) >> FRAC_BITS is at most 25500,
	// then duty = y / 100 through a reciprocal that is exact over that range.
	localparam int          SCALED_W    = 15;
	localparam logic [7:0]  DUTY_FULL   = 8'd255;
	localparam int          RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] DUTY_RECIP = 16'd41944;
	localparam int          DUTY_SHIFT  = 22;

	localparam logic [TMS_W-1:0] TMS_RESET = 15'd2000;

	// Register map, one 32-bit word per register.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_TRANSITION = 2'd0;
	localparam logic [1:0] REG_PWM_EN     = 2'd1;
	localparam logic [1:0] REG_INVERT     = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ON   = 2'd1,
		CMD_OFF  = 2'd2,
		CMD_SET  = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic exec;
		logic div_step;
		logic div_apply;
		logic scale;
		logic emit;
	} lfd_cmd_t;

	typedef struct packed {
		logic need_div;
	} lfd_status_t;

endpackage

// ===== rtl/core/led_fade_dimmer_unit.sv =====
// Linear LED fade dimmer.
//
// Requests arrive on the cmd channel (cmd_valid, cmd_stall) carrying a command
// and a brightness value. Each request produces exactly one result on the res
// channel (res_valid, res_stall): PWM duty, digital pin level, switch state and
// the integer brightness after the command has taken effect.
//
// The block works on one request at a time and stalls the cmd channel until
// it is back in idle. A tick, or a command that leaves the target alone or
// changes the level at once, passes through the scale and emit states, and
// res_valid rises when the emit state registers the result, which can be
// taken at the same edge where the next request is taken. A new target that
// starts a fade first runs a restoring divider for the per-millisecond
// increment, one quotient bit per cycle over the 23-bit level, then applies it.
//
// Reset clears the level, the target and the increment, restores the on-level
// to 100 percent and loads the registers with a 2000 ms fade, PWM enabled and
// a non-inverted pin. When the receiver holds res_stall high, the result stays
// in its register and the block finishes at most one more request up to its
// output stage, then stalls the cmd channel. Registers must be written over
// the APB port only while idle, unchecked by the block; pready is always high.
module led_fade_dimmer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [1:0]                 command,
	input  logic [6:0]                 brightness_value,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [7:0]                 pwm_duty,
	output logic                       pin_level,
	output logic                       switch_on,
	output logic [6:0]                 brightness_now
);
	import lfd_pkg::*;

	// Configuration registers.
	logic [TMS_W-1:0] transition_ms_q;
	logic             pwm_enable_q;
	logic             output_inverted_q;
	logic             wr_en;

	lfd_cmd_t    cmd;
	lfd_status_t status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transition_ms_q   <= TMS_RESET;
			pwm_enable_q      <= 1'b1;
			output_inverted_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TRANSITION: transition_ms_q   <= pwdata[TMS_W-1:0];
				REG_PWM_EN:     pwm_enable_q      <= pwdata[0];
				REG_INVERT:     output_inverted_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register reads; unmapped addresses read as zero.
	always_comb begin
		unique case (paddr[3:2])
			REG_TRANSITION: prdata = {{(32 - TMS_W){1'b0}}, transition_ms_q};
			REG_PWM_EN:     prdata = {31'd0, pwm_enable_q};
			REG_INVERT:     prdata = {31'd0, output_inverted_q};
			default:        prdata = 32'd0;
		endcase
	end

	// The controller sequences each request; the datapath holds the level
	// state, the divider and the result register.
	lfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lfd_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.command          (command),
		.brightness_value (brightness_value),
		.transition_ms    (transition_ms_q),
		.pwm_enable       (pwm_enable_q),
		.output_inverted  (output_inverted_q),
		.pwm_duty         (pwm_duty),
		.pin_level        (pin_level),
		.switch_on        (switch_on),
		.brightness_now   (brightness_now)
	);

endmodule

// ===== rtl/core/lfd_dpath.sv =====
module lfd_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfd_pkg::lfd_cmd_t           cmd,
	output lfd_pkg::lfd_status_t        status,
	input  logic [1:0]                  command,
	input  logic [6:0]                  brightness_value,
	input  logic [lfd_pkg::TMS_W-1:0]   transition_ms,
	input  logic                        pwm_enable,
	input  logic                        output_inverted,
	output logic [7:0]                  pwm_duty,
	output logic                        pin_level,
	output logic                        switch_on,
	output logic [6:0]                  brightness_now
);
	import lfd_pkg::*;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {PCT_MAX, {FRAC_BITS{1'b0}}};
	localparam logic [LEVEL_W-1:0] LEVEL_ON  = {PCT_ON_MIN, {FRAC_BITS{1'b0}}};

	logic [LEVEL_W-1:0]       level_q;
	logic [PCT_W-1:0]         target_q;
	logic [PCT_W-1:0]         on_level_q;
	logic signed [STEP_W-1:0] step_q;

	logic [LEVEL_W-1:0]       quo_q;
	logic [TMS_W-1:0]         rem_q;
	logic                     neg_q;

	logic [SCALED_W-1:0]      scaled_q;
	logic                     is_on_q;
	logic [PCT_W-1:0]         bri_q;

	cmd_code_t                code;
	logic [PCT_W-1:0]         val_sat;
	logic [PCT_W-1:0]         pct;
	logic [LEVEL_W-1:0]       goal_new;
	logic [LEVEL_W-1:0]       goal_cur;
	logic                     retarget;
	logic                     immediate;
	logic signed [LEVEL_W:0]  delta;
	logic [LEVEL_W:0]         delta_abs;
	logic signed [LEVEL_W+1:0] sum_ext;
	logic signed [LEVEL_W+1:0] goal_ext;
	logic signed [LEVEL_W+1:0] clamped;
	logic [TMS_W+1:0]         trial;
	logic [LEVEL_W-1:0]       q_mag;
	logic signed [STEP_W-1:0] step_new;
	logic [LEVEL_W+7:0]       level_x255;
	logic [SCALED_W+RECIP_W-1:0] duty_prod;

	always_comb begin
		code     = cmd_code_t'(command);
		val_sat  = (brightness_value > PCT_MAX) ? PCT_MAX : brightness_value;
		case (code)
			CMD_ON:  pct = on_level_q;
			CMD_OFF: pct = '0;
			default: pct = val_sat;
		endcase
		goal_new  = {pct, {FRAC_BITS{1'b0}}};
		goal_cur  = {target_q, {FRAC_BITS{1'b0}}};
		retarget  = (code != CMD_TICK) && (pct != target_q);
		immediate = (transition_ms == '0) || !pwm_enable
			|| (level_q[LEVEL_W-1 -: PCT_W] == pct);
		status.need_div = retarget && !immediate;

		delta     = $signed({1'b0, goal_new}) - $signed({1'b0, level_q});
		delta_abs = delta[LEVEL_W] ? -delta : delta;

		// A tick moves toward the target and never past it.
		sum_ext  = $signed({2'b00, level_q}) + $signed({step_q[STEP_W-1], step_q});
		goal_ext = $signed({2'b00, goal_cur});
		clamped  = sum_ext;
		if (step_q > 0) begin
			if (sum_ext > goal_ext) begin
				clamped = goal_ext;
			end
		end else begin
			if (sum_ext < goal_ext) begin
				clamped = goal_ext;
			end
		end

		trial    = {1'b0, rem_q, quo_q[LEVEL_W-1]} - {2'b00, transition_ms};

		q_mag    = (quo_q == '0) ? LEVEL_W'(1) : quo_q;
		step_new = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

		level_x255 = ({8'd0, level_q} << 8) - {8'd0, level_q};
		duty_prod  = scaled_q * DUTY_RECIP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			target_q   <= '0;
			on_level_q <= ON_LEVEL_RESET;
			step_q     <= '0;
		end else begin
			if (cmd.exec) begin
				if (code == CMD_TICK) begin
					if (level_q != goal_cur) begin
						level_q <= clamped[LEVEL_W-1:0];
					end
				end else begin
					if (code == CMD_SET) begin
						on_level_q <= val_sat;
					end
					if (retarget) begin
						target_q <= pct;
						if (immediate) begin
							level_q <= goal_new;
							step_q  <= '0;
						end
					end
				end
			end
			if (cmd.div_apply) begin
				step_q <= step_new;
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			quo_q <= delta_abs[LEVEL_W-1:0];
			rem_q <= '0;
			neg_q <= delta[LEVEL_W];
		end else if (cmd.div_step) begin
			if (!trial[TMS_W+1]) begin
				rem_q <= trial[TMS_W-1:0];
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[TMS_W-2:0], quo_q[LEVEL_W-1]};
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_q <= level_x255[FRAC_BITS +: SCALED_W];
			is_on_q  <= level_q > LEVEL_ON;
			bri_q    <= level_q[FRAC_BITS +: PCT_W];
		end
		if (cmd.emit) begin
			pwm_duty       <= pwm_enable ? duty_prod[DUTY_SHIFT +: 8] : 8'd0;
			pin_level      <= pwm_enable ? 1'b0 : (is_on_q ^ output_inverted);
			switch_on      <= (target_q != '0);
			brightness_now <= bri_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) level_q <= LEVEL_MAX)
		else $error("level exceeds full scale");

	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_apply |=> step_q != '0)
		else $error("fade increment is zero after division");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> duty_prod[DUTY_SHIFT +: 8] <= DUTY_FULL)
		else $error("duty out of range");

endmodule

// ===== rtl/core/lfd_ctrl.sv =====
module lfd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	output logic                  res_valid,
	input  logic                  res_stall,
	input  lfd_pkg::lfd_status_t  status,
	output lfd_pkg::lfd_cmd_t     cmd
);
	import lfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_SCALE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             res_valid_q;
	logic             slot_free;

	assign slot_free = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd.exec      = (state_q == ST_IDLE) && cmd_valid;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.div_apply = (state_q == ST_APPLY);
		cmd.scale     = (state_q == ST_SCALE);
		cmd.emit      = (state_q == ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (status.need_div) begin
							state_q <= ST_DIV;
							cnt_q   <= CNT_W'(LEVEL_W - 1);
						end else begin
							state_q <= ST_SCALE;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_APPLY: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_valid_q || !res_stall))
		else $error("result overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_APPLY)
		else $error("divider did not finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_apply |-> $past(state_q) == ST_DIV)
		else $error("increment applied without division");

endmodule
